[rtl/core/dri_pkg.sv]
// Shared types, constants and the arctangent table for the dead-reckoning integrator.
// No dependencies.
package dri_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_TABLE_LEN   = 24;
  localparam int IDX_W             = 5;
  localparam int DIV_STEPS         = 4;

  localparam logic signed [23:0] HEADING_GAIN = 24'sd5468522;
  localparam logic signed [17:0] INV_GAIN     = 18'sd39797;
  localparam logic [21:0]        DIV_DEN      = 22'd1000000;
  localparam logic [21:0]        DIV_DEN2     = 22'd2000000;
  localparam logic [21:0]        DIV_DEN3     = 22'd3000000;
  localparam logic [47:0]        DIV_HALF     = 48'd500000;
  // floor(2^44 / 10^6)
  localparam logic [24:0]        DIV_RECIP    = 25'd17592186;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PSUM, ST_PMUL, ST_HEAD, ST_ROT,
    ST_GAIN, ST_SCALE, ST_DINIT, ST_DIV, ST_UPD
  } state_t;

  typedef struct packed {
    logic             load;
    logic             psum;
    logic             pmul;
    logic             head;
    logic             rot;
    logic             gain;
    logic             scale;
    logic             dinit;
    logic             div;
    logic             upd;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } dp_stat_t;

  // atan(2^-i) in binary-angle units, 2^32 per turn
  function automatic logic [29:0] atan_bam(input logic [IDX_W-1:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/dri_ctrl.sv]
// Sequencer for the dead-reckoning integrator.
// Depends on dri_pkg; drives dri_datapath through dp_cmd_t.
module dri_ctrl import dri_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam int ROT_N = (CORDIC_STAGES < ANGLE_TABLE_LEN) ? CORDIC_STAGES : ANGLE_TABLE_LEN;
  localparam logic [IDX_W-1:0] ROT_LAST = IDX_W'(ROT_N - 1);
  localparam logic [IDX_W-1:0] DIV_LAST = IDX_W'(DIV_STEPS - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.idx    = cnt;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = ST_PSUM;
      end
      ST_PSUM: begin
        cmd.psum   = 1'b1;
        state_next = ST_PMUL;
      end
      ST_PMUL: begin
        cmd.pmul   = 1'b1;
        state_next = ST_HEAD;
      end
      ST_HEAD: begin
        cmd.head   = 1'b1;
        cnt_next   = '0;
        state_next = ST_ROT;
      end
      ST_ROT: begin
        cmd.rot = 1'b1;
        if (cnt == ROT_LAST) begin
          cnt_next   = '0;
          state_next = ST_GAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_GAIN: begin
        cmd.gain   = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.dinit  = 1'b1;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = ST_UPD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_UPD: begin
        // wait until the previous result has left
        if (!stat.out_blocked) begin
          cmd.upd    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/dri_datapath.sv]
// Datapath: heading integration, iterative CORDIC, gain, scaling and
// reciprocal-multiply division by 10^6. Depends on dri_pkg.
module dri_datapath import dri_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic signed [15:0]  velocity_forward,
  input  logic signed [15:0]  velocity_lateral,
  input  logic signed [15:0]  yaw_rate,
  input  logic        [9:0]   step_ms,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [47:0]  north_out,
  output logic signed [47:0]  east_out
);

  logic signed [15:0] vf, vl, yaw, yaw_prev;
  logic        [9:0]  dt;
  logic        [31:0] heading;
  logic signed [27:0] p;
  logic signed [51:0] hp;
  logic signed [35:0] x, y;
  logic signed [33:0] z;
  logic signed [53:0] g    [2];
  logic signed [47:0] s    [2];
  logic        [47:0] mr   [2];
  logic        [47:0] prod [2];
  logic        [21:0] rem  [2];
  logic        [25:0] q    [2];
  logic               sgn  [2];
  logic signed [47:0] pos  [2];

  // heading update and quadrant fold
  logic signed [51:0] hr;
  logic        [31:0] heading_new;
  logic signed [33:0] z0;
  logic signed [35:0] x0, y0;
  logic signed [35:0] xs, ys;
  logic signed [33:0] at;

  always_comb begin
    hr          = hp + 52'sd32768;
    heading_new = heading + hr[47:16];
    z0          = 34'(signed'(heading_new));
    x0          = {{4{vf[15]}}, vf, 16'b0};
    y0          = {{4{vl[15]}}, vl, 16'b0};
    xs          = x >>> cmd.idx;
    ys          = y >>> cmd.idx;
    at          = signed'({4'b0, atan_bam(cmd.idx)});
  end

  // per-lane combinational helpers
  logic signed [53:0] rx   [2];
  logic signed [36:0] dn   [2];
  logic        [47:0] mag  [2];
  logic        [47:0] m    [2];
  logic        [48:0] hq   [2];
  logic        [25:0] qc   [2];
  logic signed [26:0] qs   [2];
  logic signed [48:0] psum [2];
  logic signed [47:0] pnew [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rx[l]   = g[l] + 54'sd32768;
      dn[l]   = rx[l][52:16];
      mag[l]  = s[l][47] ? 48'(-s[l]) : 48'(s[l]);
      m[l]    = mag[l] + DIV_HALF;
      // quotient estimate from the top bits, low by at most three
      hq[l]   = 49'(mr[l][43:20]) * 49'(DIV_RECIP);
      qc[l]   = q[l] + 26'(rem[l] >= DIV_DEN3) + 26'(rem[l] >= DIV_DEN2)
              + 26'(rem[l] >= DIV_DEN);
      qs[l]   = sgn[l] ? -signed'({1'b0, q[l]}) : signed'({1'b0, q[l]});
      psum[l] = {pos[l][47], pos[l]} + 49'(qs[l]);
      if (psum[l][48] != psum[l][47])
        pnew[l] = psum[l][48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
      else
        pnew[l] = psum[l][47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vf  <= velocity_forward;
      vl  <= velocity_lateral;
      yaw <= yaw_rate;
      dt  <= step_ms;
    end
    if (cmd.psum)
      p <= 28'(signed'({1'b0, dt})) * 28'(17'(yaw_prev) + 17'(yaw));
    if (cmd.pmul)
      hp <= 52'(p) * 52'(HEADING_GAIN);
    if (cmd.head) begin
      if (z0 > 34'sd1073741824) begin
        x <= -x0;
        y <= -y0;
        z <= z0 - 34'sd2147483648;
      end else if (z0 < -34'sd1073741824) begin
        x <= -x0;
        y <= -y0;
        z <= z0 + 34'sd2147483648;
      end else begin
        x <= x0;
        y <= y0;
        z <= z0;
      end
    end
    if (cmd.rot) begin
      if (!z[33]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
    if (cmd.gain) begin
      g[0] <= 54'(x) * 54'(INV_GAIN);
      g[1] <= 54'(y) * 54'(INV_GAIN);
    end
    for (int l = 0; l < 2; l++) begin
      if (cmd.scale)
        s[l] <= 48'(signed'({1'b0, dt})) * 48'(dn[l]);
      if (cmd.dinit) begin
        sgn[l] <= s[l][47];
        mr[l]  <= m[l];
      end
      if (cmd.div) begin
        unique case (cmd.idx)
          IDX_W'(0): q[l]    <= 26'(hq[l][48:24]);
          IDX_W'(1): prod[l] <= 48'(q[l]) * 48'(DIV_DEN);
          IDX_W'(2): rem[l]  <= 22'(mr[l] - prod[l]);
          IDX_W'(3): q[l]    <= qc[l];
          default: ;
        endcase
      end
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_prev  <= '0;
      heading   <= '0;
      pos[0]    <= '0;
      pos[1]    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.head) begin
        heading  <= heading_new;
        yaw_prev <= yaw;
      end
      if (cmd.upd) begin
        pos[0]    <= pnew[0];
        pos[1]    <= pnew[1];
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.out_blocked = out_valid && out_stall;
  assign north_out        = pos[0];
  assign east_out         = pos[1];

endmodule

[rtl/core/dead_reckoning_integrator.sv]
// Top level of the planar dead-reckoning integrator.
// Depends on dri_pkg, dri_ctrl and dri_datapath.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------
//  in      | in_valid / in_stall | velocity_forward, velocity_lateral, yaw_rate, step_ms
//  out     | out_valid/out_stall | north_out, east_out
//
// One sample is processed at a time, with one CORDIC iteration per cycle over
// min(CORDIC_STAGES, 24) table entries and a 4-step reciprocal-multiply
// division by 10^6; no new sample is taken until the previous one is updated.
// A finished position sits in the output register; the next sample is taken
// while it waits, and only the final update step holds for out_stall.
// Reset zeroes heading, previous yaw rate and both positions.
module dead_reckoning_integrator import dri_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] velocity_forward,
  input  logic signed [15:0] velocity_lateral,
  input  logic signed [15:0] yaw_rate,
  input  logic        [9:0]  step_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] north_out,
  output logic signed [47:0] east_out
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dri_ctrl #(.CORDIC_STAGES(CORDIC_STAGES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dri_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .velocity_forward (velocity_forward),
    .velocity_lateral (velocity_lateral),
    .yaw_rate         (yaw_rate),
    .step_ms          (step_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .north_out        (north_out),
    .east_out         (east_out)
  );

endmodule

[rtl/core/dri_checker.sv]
// Port-level checks for the dead-reckoning integrator, bound to the top level.
// Depends on dead_reckoning_integrator.
module dri_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [47:0] north_out,
  input logic signed [47:0] east_out
);

  // a stalled result transaction stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(north_out) && $stable(east_out))
    else $error("stalled result changed");

  // once a sample is taken the block is busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // no result can appear in the cycle right after an acceptance
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result too early");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("reset did not clear handshake state");

endmodule

bind dead_reckoning_integrator dri_checker u_dri_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .north_out (north_out),
  .east_out  (east_out)
);
